// ----- rtl/clpm_pkg.sv -----
package clpm_pkg;

    // Sizing
    localparam int NUM_SLOTS     = 8;
    localparam int SLOT_W        = 3;
    localparam int OP_W          = 2;
    localparam int ACT_W         = 4;
    localparam int WIN_W         = 16;
    localparam int CNT_W         = 32;
    localparam int PCT_W         = 7;
    localparam int IDX_W         = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_AW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TOT_W         = CNT_W + IDX_W;
    localparam int PROD_W        = CNT_W + PCT_W;
    localparam int STEP_W        = $clog2(PCT_W + 1);
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int OUTQ_DEPTH    = 2;
    localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET  = 16'd1000;
    localparam int               PERCENT_SCALE = 100;

    // Event codes
    typedef enum logic [OP_W-1:0] {
        OP_COUNT_SLOT = 2'd0,
        OP_COUNT_IDLE = 2'd1,
        OP_TICK       = 2'd2,
        OP_READ       = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_SLOTS = 1'b0,
        REG_WINDOW_TICKS = 1'b1
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic sum_step;
        logic idx_clear;
        logic mul_load;
        logic div_start;
        logic write_pct;
        logic close_done;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic close_hit;
        logic idx_at_live;
        logic div_busy;
    } dp_status_t;

    // One result beat
    typedef struct packed {
        logic [PCT_W-1:0] slot_usage;
        logic [PCT_W-1:0] idle_usage;
        logic             window_closed;
    } result_t;

endpackage

// ----- rtl/cpu_load_percentage_monitor_unit.sv -----
// CPU load percentage monitor.
// Input channel (in_valid/in_stall) carries one event per beat: count for a
// slot, count idle, a millisecond tick, or read a slot's usage. Every event
// yields exactly one result beat on the output channel (out_valid/out_stall):
// the stored percent of the addressed slot (0 for an unregistered slot), the
// stored idle percent, and window_closed for the tick that ended a window.
// Count, read and non-closing tick events are taken one per cycle while the
// result buffer has room; each result is registered into that buffer. A
// closing tick holds in_stall high while the window is summed and each percent
// is divided out by a shared divider that yields one quotient bit per cycle.
// Results sit in a two-beat buffer, so events keep flowing while the receiver
// stalls; in_stall rises once that buffer is full.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and are
// to be made by the user only while no event is in flight; the block itself
// does not enforce this. Reset clears all counters and percents, sets zero
// registered slots and a window of 1000 ticks, and empties the result buffer.
module cpu_load_percentage_monitor_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [clpm_pkg::OP_W-1:0]         opcode,
    input  logic [clpm_pkg::SLOT_W-1:0]       slot,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [clpm_pkg::PCT_W-1:0]        slot_usage,
    output logic [clpm_pkg::PCT_W-1:0]        idle_usage,
    output logic                              window_closed,
    input  logic                              cfg_we,
    input  logic [clpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    clpm_pkg::dp_cmd_t    cmd;
    clpm_pkg::dp_status_t status;
    clpm_pkg::result_t    result;
    clpm_pkg::result_t    dout;
    logic                 push;
    logic                 q_full;

    clpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .q_full   (q_full),
        .status   (status),
        .in_stall (in_stall),
        .push     (push),
        .cmd      (cmd)
    );

    clpm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (opcode),
        .slot      (slot),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    clpm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full      (q_full),
        .dout      (dout)
    );

    assign slot_usage    = dout.slot_usage;
    assign idle_usage    = dout.idle_usage;
    assign window_closed = dout.window_closed;

endmodule

// ----- rtl/clpm_div.sv -----
module clpm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [clpm_pkg::PROD_W-1:0]   dividend,
    input  logic [clpm_pkg::TOT_W-1:0]    divisor,
    output logic                          busy,
    output logic [clpm_pkg::PCT_W-1:0]    quotient
);

    logic [clpm_pkg::TOT_W-1:0]  rem_reg, rem_next;
    logic [clpm_pkg::PCT_W-1:0]  lo_reg, lo_next;
    logic [clpm_pkg::PCT_W-1:0]  quo_reg, quo_next;
    logic [clpm_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic [clpm_pkg::TOT_W:0]    shifted;
    logic [clpm_pkg::TOT_W:0]    diff;
    logic                        ge;

    // Bring down one dividend bit and trial-subtract the divisor
    assign shifted = {rem_reg, lo_reg[clpm_pkg::PCT_W-1]};
    assign ge      = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    // Load on start, then one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = clpm_pkg::TOT_W'(dividend[clpm_pkg::PROD_W-1:clpm_pkg::PCT_W]);
            lo_next   = dividend[clpm_pkg::PCT_W-1:0];
            quo_next  = '0;
            step_next = clpm_pkg::STEP_W'(clpm_pkg::PCT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[clpm_pkg::TOT_W-1:0] : shifted[clpm_pkg::TOT_W-1:0];
            lo_next   = lo_reg << 1;
            quo_next  = {quo_reg[clpm_pkg::PCT_W-2:0], ge};
            step_next = step_reg - clpm_pkg::STEP_W'(1);
            if (step_reg == clpm_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // A division always runs the full quotient width
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(start, clpm_pkg::PCT_W + 1))
        else $error("divider finished after the wrong number of steps");

endmodule

// ----- rtl/clpm_dp.sv -----
module clpm_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [clpm_pkg::OP_W-1:0]         opcode,
    input  logic [clpm_pkg::SLOT_W-1:0]       slot,
    input  logic                              cfg_we,
    input  logic [clpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clpm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  clpm_pkg::dp_cmd_t                 cmd,
    output clpm_pkg::dp_status_t              status,
    output clpm_pkg::result_t                 result
);

    logic [clpm_pkg::ACT_W-1:0]   active_reg, active_next;
    logic [clpm_pkg::WIN_W-1:0]   window_reg, window_next;
    logic [clpm_pkg::CNT_W-1:0]   count_reg [clpm_pkg::NUM_SLOTS];
    logic [clpm_pkg::CNT_W-1:0]   count_next [clpm_pkg::NUM_SLOTS];
    logic [clpm_pkg::PCT_W-1:0]   pct_reg [clpm_pkg::NUM_SLOTS];
    logic [clpm_pkg::PCT_W-1:0]   pct_next [clpm_pkg::NUM_SLOTS];
    logic [clpm_pkg::CNT_W-1:0]   idle_cnt_reg, idle_cnt_next;
    logic [clpm_pkg::PCT_W-1:0]   idle_pct_reg, idle_pct_next;
    logic [clpm_pkg::WIN_W-1:0]   tick_reg, tick_next;
    logic [clpm_pkg::SLOT_W-1:0]  rd_slot_reg, rd_slot_next;
    logic [clpm_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [clpm_pkg::TOT_W-1:0]   total_reg, total_next;
    logic [clpm_pkg::PROD_W-1:0]  prod_reg, prod_next;

    logic [clpm_pkg::IDX_W-1:0]   live;
    logic [clpm_pkg::IDX_W-1:0]   new_live;
    logic                         slot_valid;
    logic [clpm_pkg::SLOT_W-1:0]  out_slot;
    logic                         out_slot_valid;
    logic [clpm_pkg::SLOT_AW-1:0] cnt_addr;
    logic [clpm_pkg::SLOT_AW-1:0] pct_addr;
    logic [clpm_pkg::CNT_W-1:0]   count_rd;
    logic [clpm_pkg::CNT_W-1:0]   part;
    logic [clpm_pkg::WIN_W-1:0]   limit;
    logic [clpm_pkg::WIN_W-1:0]   tick_inc;
    logic                         close_hit;
    logic                         idx_at_live;
    logic                         div_busy;
    logic [clpm_pkg::PCT_W-1:0]   quotient;
    logic [clpm_pkg::PCT_W-1:0]   pct_new;

    // Registered slot count above the array size acts as the array size
    function automatic logic [clpm_pkg::IDX_W-1:0] clamp_live(
        input logic [clpm_pkg::ACT_W-1:0] a
    );
        logic [clpm_pkg::IDX_W-1:0] r;
        if (int'(a) > clpm_pkg::NUM_SLOTS)
        begin
            r = clpm_pkg::IDX_W'(clpm_pkg::NUM_SLOTS);
        end
        else
        begin
            r = clpm_pkg::IDX_W'(a);
        end
        return r;
    endfunction

    assign live     = clamp_live(active_reg);
    assign new_live = clamp_live(cfg_data[clpm_pkg::ACT_W-1:0]);

    // Slot checks for the incoming event and for the reported slot
    assign slot_valid     = int'(slot) < int'(live);
    assign out_slot       = cmd.close_done ? rd_slot_reg : slot;
    assign out_slot_valid = int'(out_slot) < int'(live);

    // Counter port: event slot while taking an event, sweep index otherwise
    assign cnt_addr = cmd.accept ? clpm_pkg::SLOT_AW'(slot)
                                 : idx_reg[clpm_pkg::SLOT_AW-1:0];
    assign count_rd = count_reg[cnt_addr];
    assign pct_addr = clpm_pkg::SLOT_AW'(out_slot);

    assign idx_at_live = idx_reg == live;
    assign part        = idx_at_live ? idle_cnt_reg : count_rd;

    // Window tick compare
    assign limit     = (window_reg == '0) ? clpm_pkg::WIN_W'(1) : window_reg;
    assign tick_inc  = tick_reg + clpm_pkg::WIN_W'(1);
    assign close_hit = (clpm_pkg::opcode_t'(opcode) == clpm_pkg::OP_TICK)
                       && (tick_inc >= limit);

    // An empty window reports zero everywhere
    assign pct_new = (total_reg == '0) ? '0 : quotient;

    clpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (total_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status = '{close_hit: close_hit, idx_at_live: idx_at_live, div_busy: div_busy};

    assign result = '{slot_usage:    out_slot_valid ? pct_reg[pct_addr] : '0,
                      idle_usage:    idle_pct_reg,
                      window_closed: cmd.close_done};

    // Next-state logic for configuration, counters and the close sweep
    always_comb
    begin
        active_next   = active_reg;
        window_next   = window_reg;
        count_next    = count_reg;
        pct_next      = pct_reg;
        idle_cnt_next = idle_cnt_reg;
        idle_pct_next = idle_pct_reg;
        tick_next     = tick_reg;
        rd_slot_next  = rd_slot_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        prod_next     = prod_reg;

        // Configuration writes; dropping slots clears them
        if (cfg_we)
        begin
            unique case (clpm_pkg::cfg_reg_t'(cfg_index))
                clpm_pkg::REG_ACTIVE_SLOTS:
                begin
                    active_next = cfg_data[clpm_pkg::ACT_W-1:0];
                    for (int i = 0; i < clpm_pkg::NUM_SLOTS; i++)
                    begin
                        if (i >= int'(new_live))
                        begin
                            count_next[i] = '0;
                            pct_next[i]   = '0;
                        end
                    end
                end
                clpm_pkg::REG_WINDOW_TICKS:
                begin
                    window_next = cfg_data[clpm_pkg::WIN_W-1:0];
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end

        // Event beat
        if (cmd.accept)
        begin
            rd_slot_next = slot;
            unique case (clpm_pkg::opcode_t'(opcode))
                clpm_pkg::OP_COUNT_SLOT:
                begin
                    if (slot_valid && (count_rd != '1))
                    begin
                        count_next[cnt_addr] = count_rd + clpm_pkg::CNT_W'(1);
                    end
                end
                clpm_pkg::OP_COUNT_IDLE:
                begin
                    if (idle_cnt_reg != '1)
                    begin
                        idle_cnt_next = idle_cnt_reg + clpm_pkg::CNT_W'(1);
                    end
                end
                clpm_pkg::OP_TICK:
                begin
                    if (close_hit)
                    begin
                        tick_next  = '0;
                        total_next = clpm_pkg::TOT_W'(idle_cnt_reg);
                        idx_next   = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                clpm_pkg::OP_READ:
                begin
                    tick_next = tick_reg;
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end

        // Accumulate the window total
        if (cmd.sum_step)
        begin
            total_next = total_reg + clpm_pkg::TOT_W'(count_rd);
            idx_next   = idx_reg + clpm_pkg::IDX_W'(1);
        end

        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end

        // Scale the current part by the percent factor
        if (cmd.mul_load)
        begin
            prod_next = clpm_pkg::PROD_W'(part) * clpm_pkg::PROD_W'(clpm_pkg::PERCENT_SCALE);
        end

        // Store the percent and clear the counter
        if (cmd.write_pct)
        begin
            if (idx_at_live)
            begin
                idle_pct_next = pct_new;
                idle_cnt_next = '0;
            end
            else
            begin
                pct_next[idx_reg[clpm_pkg::SLOT_AW-1:0]]   = pct_new;
                count_next[idx_reg[clpm_pkg::SLOT_AW-1:0]] = '0;
            end
            idx_next = idx_reg + clpm_pkg::IDX_W'(1);
        end
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            window_reg   <= clpm_pkg::WINDOW_RESET;
            idle_cnt_reg <= '0;
            idle_pct_reg <= '0;
            tick_reg     <= '0;
            idx_reg      <= '0;
            for (int i = 0; i < clpm_pkg::NUM_SLOTS; i++)
            begin
                count_reg[i] <= '0;
                pct_reg[i]   <= '0;
            end
        end
        else
        begin
            active_reg   <= active_next;
            window_reg   <= window_next;
            idle_cnt_reg <= idle_cnt_next;
            idle_pct_reg <= idle_pct_next;
            tick_reg     <= tick_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            pct_reg      <= pct_next;
        end
    end

    // Sweep payload
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        total_reg   <= total_next;
        prod_reg    <= prod_next;
    end

    // Summing only touches registered slots
    a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_step |-> (idx_reg < live))
        else $error("window sum stepped past the registered slots");

    // A nonzero window never yields more than full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_pct && (total_reg != '0))
        |-> (quotient <= clpm_pkg::PCT_W'(clpm_pkg::PERCENT_SCALE)))
        else $error("computed percent above full scale");

endmodule

// ----- rtl/clpm_ctrl.sv -----
module clpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  q_full,
    input  clpm_pkg::dp_status_t  status,
    output logic                  in_stall,
    output logic                  push,
    output clpm_pkg::dp_cmd_t     cmd
);

    clpm_pkg::state_t state_reg, state_next;
    logic             accept;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        push       = 1'b0;
        in_stall   = (state_reg != clpm_pkg::ST_IDLE) || q_full;
        accept     = in_valid && !in_stall;

        unique case (state_reg)
            clpm_pkg::ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (status.close_hit)
                    begin
                        state_next = clpm_pkg::ST_SUM;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
            end
            clpm_pkg::ST_SUM:
            begin
                if (status.idx_at_live)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = clpm_pkg::ST_MUL;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                end
            end
            clpm_pkg::ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = clpm_pkg::ST_DLOAD;
            end
            clpm_pkg::ST_DLOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = clpm_pkg::ST_DIV;
            end
            clpm_pkg::ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = clpm_pkg::ST_WRITE;
                end
            end
            clpm_pkg::ST_WRITE:
            begin
                cmd.write_pct = 1'b1;
                state_next    = status.idx_at_live ? clpm_pkg::ST_DONE : clpm_pkg::ST_MUL;
            end
            clpm_pkg::ST_DONE:
            begin
                cmd.close_done = 1'b1;
                push           = 1'b1;
                state_next     = clpm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = clpm_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A closing tick always starts the window sum
    a_close_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.close_hit) |=> (state_reg == clpm_pkg::ST_SUM))
        else $error("closing tick did not start the window sum");

endmodule

// ----- rtl/clpm_outq.sv -----
module clpm_outq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  clpm_pkg::result_t                    din,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic                                 full,
    output clpm_pkg::result_t                    dout
);

    clpm_pkg::result_t                e0_reg, e0_next;
    clpm_pkg::result_t                e1_reg, e1_next;
    logic [clpm_pkg::OUTQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [clpm_pkg::OUTQ_CNT_W-1:0]  fill;
    logic                             pop;

    assign out_valid = cnt_reg != '0;
    assign full      = cnt_reg == clpm_pkg::OUTQ_CNT_W'(clpm_pkg::OUTQ_DEPTH);
    assign pop       = out_valid && !out_stall;
    assign fill      = cnt_reg - clpm_pkg::OUTQ_CNT_W'(pop);
    assign dout      = e0_reg;

    // Advance the head on a taken beat, write the new beat behind it
    always_comb
    begin
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        if (pop)
        begin
            e0_next = e1_reg;
        end
        if (push)
        begin
            if (fill == '0)
            begin
                e0_next = din;
            end
            else
            begin
                e1_next = din;
            end
        end
        cnt_next = cnt_reg + clpm_pkg::OUTQ_CNT_W'(push) - clpm_pkg::OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    // Never write into a full buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("result buffer overflow");

endmodule

// ----- dv/cpu_load_percentage_monitor_unit_tb.sv -----
module cpu_load_percentage_monitor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clpm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_GUARD   = 4;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 150;

    // Load predictor and result store
    class load_scoreboard;
        logic [CNT_W-1:0] slot_cnt [NUM_SLOTS];
        logic [PCT_W-1:0] slot_pct [NUM_SLOTS];
        logic [CNT_W-1:0] idle_cnt;
        logic [PCT_W-1:0] idle_pct;
        logic [WIN_W-1:0] tick_cnt;
        logic [ACT_W-1:0] act_slots;
        logic [WIN_W-1:0] win_ticks;
        result_t          usage_q [$];
        int               errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_cnt[i] = '0;
                slot_pct[i] = '0;
            end
            idle_cnt  = '0;
            idle_pct  = '0;
            tick_cnt  = '0;
            act_slots = '0;
            win_ticks = WINDOW_RESET;
            errors    = 0;
        endfunction

        function int live_slots();
            return (act_slots > NUM_SLOTS) ? NUM_SLOTS : int'(act_slots);
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function logic [PCT_W-1:0] percent_of(logic [CNT_W-1:0] part, logic [63:0] total);
            logic [63:0] prod;
            prod = {32'b0, part} * 64'd100;
            if (total == 0)
                return '0;
            return PCT_W'(prod / total);
        endfunction

        // Sum the window, store every percent, clear the counters
        function void close_window();
            logic [63:0] total;
            int          n;
            n     = live_slots();
            total = {32'b0, idle_cnt};
            for (int i = 0; i < n; i++)
                total += {32'b0, slot_cnt[i]};
            for (int i = 0; i < n; i++)
            begin
                slot_pct[i] = percent_of(slot_cnt[i], total);
                slot_cnt[i] = '0;
            end
            idle_pct = percent_of(idle_cnt, total);
            idle_cnt = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ACTIVE_SLOTS)
            begin
                act_slots = data[ACT_W-1:0];
                // Drop everything held by slots that are no longer registered
                for (int i = live_slots(); i < NUM_SLOTS; i++)
                begin
                    slot_cnt[i] = '0;
                    slot_pct[i] = '0;
                end
            end
            else
                win_ticks = data[WIN_W-1:0];
        endfunction

        function int pending();
            return usage_q.size();
        endfunction

        // Advance the predictor by one accepted event beat
        function void note_event(opcode_t op, logic [SLOT_W-1:0] s);
            result_t          r;
            logic             hit;
            logic [WIN_W-1:0] lim;
            hit = (int'(s) < live_slots());
            r.window_closed = 1'b0;
            case (op)
                OP_COUNT_SLOT:
                begin
                    if (hit)
                        slot_cnt[s] = bump(slot_cnt[s]);
                end
                OP_COUNT_IDLE:
                begin
                    idle_cnt = bump(idle_cnt);
                end
                OP_TICK:
                begin
                    lim      = (win_ticks == 0) ? WIN_W'(1) : win_ticks;
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= lim)
                    begin
                        tick_cnt = '0;
                        close_window();
                        r.window_closed = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            r.slot_usage = hit ? slot_pct[s] : '0;
            r.idle_usage = idle_pct;
            usage_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result beat with the oldest predicted usage
        task check_beat(logic [PCT_W-1:0] su, logic [PCT_W-1:0] iu, logic wc);
            result_t want;
            if (usage_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending (%0d %0d %0b)",
                                          su, iu, wc));
                return;
            end
            want = usage_q.pop_front();
            if (su !== want.slot_usage)
                report_mismatch($sformatf("slot_usage %0d, predicted %0d", su, want.slot_usage));
            if (iu !== want.idle_usage)
                report_mismatch($sformatf("idle_usage %0d, predicted %0d", iu, want.idle_usage));
            if (wc !== want.window_closed)
                report_mismatch($sformatf("window_closed %0b, predicted %0b",
                                          wc, want.window_closed));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    opcode_t               opcode        = OP_READ;
    logic [SLOT_W-1:0]     slot          = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [PCT_W-1:0]      slot_usage;
    logic [PCT_W-1:0]      idle_usage;
    logic                  window_closed;
    logic                  cfg_we        = 1'b0;
    cfg_reg_t              cfg_index     = REG_ACTIVE_SLOTS;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    load_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             cycles = 0;

    cpu_load_percentage_monitor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .slot          (slot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_usage    (slot_usage),
        .idle_usage    (idle_usage),
        .window_closed (window_closed),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hold off the result channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(slot_usage, idle_usage, window_closed);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one event beat and hold it until taken
    task send_event(opcode_t op, logic [SLOT_W-1:0] s);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        slot     <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_event(op, s);
    endtask

    // Write a register once every pending result is back
    task write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    function opcode_t pick_op(bit noisy);
        int r;
        r = $urandom_range(99, 0);
        if (noisy)
            return opcode_t'($urandom_range(3, 0));
        if (r < 40)
            return OP_COUNT_SLOT;
        if (r < 65)
            return OP_COUNT_IDLE;
        if (r < 80)
            return OP_TICK;
        return OP_READ;
    endfunction

    // Directed events: defaults, zero window, full and partial registration
    task run_directed();
        send_event(OP_READ, 3'd0);
        send_event(OP_COUNT_SLOT, 3'd3);
        send_event(OP_COUNT_IDLE, 3'd5);
        send_event(OP_TICK, 3'd1);
        write_cfg(REG_ACTIVE_SLOTS, 16'd8);
        write_cfg(REG_WINDOW_TICKS, 16'd0);
        for (int i = 0; i < NUM_SLOTS; i++)
            send_event(OP_COUNT_SLOT, SLOT_W'(i));
        send_event(OP_COUNT_SLOT, 3'd7);
        send_event(OP_COUNT_IDLE, 3'd2);
        send_event(OP_TICK, 3'd7);
        send_event(OP_READ, 3'd0);
        send_event(OP_READ, 3'd7);
        // Shrink registration: upper slots lose their percent
        write_cfg(REG_ACTIVE_SLOTS, 16'hFFF3);
        send_event(OP_READ, 3'd5);
        send_event(OP_READ, 3'd2);
        send_event(OP_COUNT_SLOT, 3'd6);
        send_event(OP_COUNT_SLOT, 3'd1);
        send_event(OP_TICK, 3'd1);
        // Nothing counted since the last close
        send_event(OP_TICK, 3'd4);
        send_event(OP_READ, 3'd1);
        write_cfg(REG_ACTIVE_SLOTS, 16'd15);
        send_event(OP_COUNT_SLOT, 3'd7);
        send_event(OP_TICK, 3'd7);
    endtask

    // Random phases across settings and idling modes
    task run_random();
        logic [ACT_W-1:0] act;
        logic [WIN_W-1:0] win;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] favored;
        int               live;
        int               r;
        bit               noisy;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       act = 4'd8;
                1:       act = 4'd0;
                2:       act = 4'd15;
                3:       act = 4'd1;
                default: act = ACT_W'($urandom_range(15, 0));
            endcase
            case (p)
                1:       win = 16'd1;
                4:       win = 16'hFFFF;
                5:       win = 16'd0;
                default: win = WIN_W'($urandom_range(10, 1));
            endcase
            write_cfg(REG_ACTIVE_SLOTS, {12'($urandom_range(4095, 0)), act});
            write_cfg(REG_WINDOW_TICKS, win);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            live    = (act > NUM_SLOTS) ? NUM_SLOTS : int'(act);
            favored = SLOT_W'($urandom_range(7, 0));
            noisy   = (p >= PHASE_COUNT - 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(99, 0);
                if (noisy || r >= 80 || live == 0)
                    s = SLOT_W'($urandom_range(7, 0));
                else if (r < 30)
                    s = favored;
                else
                    s = SLOT_W'($urandom_range(live - 1, 0));
                send_event(pick_op(noisy), s);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        // Drain the result channel, then watch for stray beats
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/clpm_pkg.sv
rtl/clpm_div.sv
rtl/clpm_dp.sv
rtl/clpm_ctrl.sv
rtl/clpm_outq.sv
rtl/cpu_load_percentage_monitor_unit.sv
dv/cpu_load_percentage_monitor_unit_tb.sv
